### rtl/core/battery_level_monitor_unit_assert.svh
// assertion macros shared by the battery level monitor checker
`ifndef BATTERY_LEVEL_MONITOR_UNIT_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("battery level monitor check failed");

// next-cycle implication, sampled on clk, off during reset
`define BLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery level monitor check failed");

`endif

### rtl/core/blm_pkg.sv
// shared types, constants and codes of the battery level monitor
package blm_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int RING_AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH + 1);
  localparam int WIN_W        = 7;
  localparam int WIN_CMP_W    = (WIN_W > COUNT_W) ? WIN_W : COUNT_W;
  localparam int MV_W         = 16;
  localparam int LVL_W        = MV_W + 3;
  localparam int CFG_IDX_W    = 3;
  localparam int STEP_W       = $clog2(SUM_W);

  localparam logic [MV_W-1:0] MIN_VALID_MV = MV_W'(500);
  localparam logic [MV_W-1:0] SECONDS_MAX  = '1;

  localparam logic [MV_W-1:0]  RST_FULL_MV  = MV_W'(25200);
  localparam logic [MV_W-1:0]  RST_EMPTY_MV = MV_W'(21000);
  localparam logic [MV_W-1:0]  RST_CRIT_MV  = MV_W'(19800);
  localparam logic [MV_W-1:0]  RST_HYST_MV  = MV_W'(300);
  localparam logic [MV_W-1:0]  RST_OC_LIMIT = MV_W'(6000);
  localparam logic [WIN_W-1:0] RST_WINDOW   = WIN_W'(10);
  localparam logic [MV_W-1:0]  RST_DEBOUNCE = MV_W'(30);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_MV    = 3'd0,
    REG_EMPTY_MV   = 3'd1,
    REG_CRIT_MV    = 3'd2,
    REG_HYST_MV    = 3'd3,
    REG_OC_LIMIT   = 3'd4,
    REG_AVG_WINDOW = 3'd5,
    REG_DEBOUNCE   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [MV_W-1:0] voltage_mv;
    logic [MV_W-1:0] current_sample;
    logic            autopilot_engaged;
  } in_t;

  typedef struct packed {
    logic            sample_taken;
    logic [MV_W-1:0] average_mv;
    logic [3:0]      level_events;
    logic            critical_event;
    logic            overcurrent_event;
    logic [MV_W-1:0] reported_current;
  } out_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_load;
    logic div_step;
    logic check;
    logic load_out;
  } blm_cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic out_free;
  } blm_status_t;

endpackage

### rtl/core/blm_ram.sv
// generic simple dual-port ram with registered read
module blm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/blm_ctrl.sv
// sequencing state machine of the battery level monitor
module blm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  blm_pkg::blm_status_t status,
  output blm_pkg::blm_cmd_t    cmd
);
  import blm_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = status.sample_ok ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        // old slot value is on the ram output now
        cmd.update = 1'b1;
        state_nxt  = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/blm_datapath.sv
// registers, ring, divider and level checks of the battery level monitor
module blm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  blm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output blm_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blm_pkg::MV_W-1:0]      cfg_data,
  input  blm_pkg::blm_cmd_t             cmd,
  output blm_pkg::blm_status_t          status
);
  import blm_pkg::*;

  // configuration
  logic [MV_W-1:0]  full_r, full_nxt, empty_r, empty_nxt, crit_mv_r, crit_mv_nxt;
  logic [MV_W-1:0]  hyst_r, hyst_nxt, oc_lim_r, oc_lim_nxt, debounce_r, debounce_nxt;
  logic [WIN_W-1:0] window_r, window_nxt;

  // item held while it is worked on
  logic [MV_W-1:0]    volt_r, volt_nxt, cur_r, cur_nxt;
  logic               ap_r, ap_nxt;
  logic [RING_AW-1:0] slot_r, slot_nxt;

  // monitor state
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [RING_AW-1:0] wslot_r, wslot_nxt;
  logic [3:0]         lev_r, lev_nxt;
  logic               crit_r, crit_nxt;
  logic [MV_W-1:0]    secs_r, secs_nxt;
  logic [MV_W-1:0]    avg_r, avg_nxt;

  // divider
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W:0]   rem_r, rem_nxt;

  out_t res_r, res_nxt;
  out_t out_data_r;
  logic out_valid_r, out_valid_nxt;

  logic [WIN_CMP_W-1:0]    win_ext;
  logic [COUNT_W-1:0]      win_eff;
  logic [RING_AW-1:0]      slot_sel;
  logic [COUNT_W-1:0]      slot_inc;
  logic                    ram_rd_en;
  logic [SAMPLE_WIDTH-1:0] ram_rd_data;
  logic [COUNT_W:0]        rem_sh;
  logic [MV_W-1:0]         avg_new;
  logic [LVL_W-1:0]        a4, h4, f_ext, e_ext;
  logic [LVL_W-1:0]        lvl [4];
  logic [MV_W:0]           crit_rel;
  logic                    oc_hit;
  logic                    cfg_we;
  logic [3:0]              lev_ev;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // window of zero acts as one, above the ring depth acts as the depth
  assign win_ext = WIN_CMP_W'(window_r);
  always_comb begin
    if (window_r == '0) begin
      win_eff = COUNT_W'(1);
    end else if (win_ext > WIN_CMP_W'(WINDOW_DEPTH)) begin
      win_eff = COUNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = COUNT_W'(win_ext);
    end
  end

  assign slot_sel = (COUNT_W'(wslot_r) >= win_eff) ? '0 : wslot_r;
  assign slot_inc = COUNT_W'(slot_r) + COUNT_W'(1);

  assign status.sample_ok = (in_data.operation == OP_SAMPLE)
                            && (in_data.voltage_mv >= MIN_VALID_MV);
  assign status.out_free  = !out_valid_r || !out_stall;
  assign ram_rd_en        = cmd.accept && status.sample_ok;

  blm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot_r),
    .wr_data (SAMPLE_WIDTH'(volt_r)),
    .rd_en   (ram_rd_en),
    .rd_addr (slot_sel),
    .rd_data (ram_rd_data)
  );

  // restoring division, one quotient bit a step
  assign rem_sh  = {rem_r[COUNT_W-1:0], quo_r[SUM_W-1]};
  assign avg_new = quo_r[MV_W-1:0];

  // levels in quarter millivolts
  assign a4       = {1'b0, avg_new, 2'b00};
  assign h4       = {1'b0, hyst_r, 2'b00};
  assign f_ext    = LVL_W'(full_r);
  assign e_ext    = LVL_W'(empty_r);
  assign lvl[0]   = (f_ext << 1) + f_ext + e_ext;
  assign lvl[1]   = (f_ext << 1) + (e_ext << 1);
  assign lvl[2]   = f_ext + (e_ext << 1) + e_ext;
  assign lvl[3]   = e_ext << 2;
  assign crit_rel = {1'b0, crit_mv_r} + {1'b0, hyst_r};
  assign oc_hit   = (cur_r > oc_lim_r) && ap_r && (secs_r >= debounce_r);

  always_comb begin
    full_nxt      = full_r;
    empty_nxt     = empty_r;
    crit_mv_nxt   = crit_mv_r;
    hyst_nxt      = hyst_r;
    oc_lim_nxt    = oc_lim_r;
    window_nxt    = window_r;
    debounce_nxt  = debounce_r;
    volt_nxt      = volt_r;
    cur_nxt       = cur_r;
    ap_nxt        = ap_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    wslot_nxt     = wslot_r;
    lev_nxt       = lev_r;
    crit_nxt      = crit_r;
    secs_nxt      = secs_r;
    avg_nxt       = avg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    lev_ev        = '0;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.accept) begin
      volt_nxt = in_data.voltage_mv;
      cur_nxt  = in_data.current_sample;
      ap_nxt   = in_data.autopilot_engaged;
      slot_nxt = slot_sel;
      res_nxt  = '0;
      res_nxt.average_mv = avg_r;
      case (in_data.operation)
        OP_TICK: begin
          if (secs_r != SECONDS_MAX) begin
            secs_nxt = secs_r + MV_W'(1);
          end
        end
        OP_CLEAR: begin
          sum_nxt   = '0;
          count_nxt = '0;
          wslot_nxt = '0;
          lev_nxt   = '0;
          crit_nxt  = 1'b0;
          avg_nxt   = '0;
          res_nxt.average_mv = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.update) begin
      if (count_r >= win_eff) begin
        sum_nxt   = sum_r - SUM_W'(ram_rd_data) + SUM_W'(volt_r);
        count_nxt = win_eff;
      end else begin
        sum_nxt   = sum_r + SUM_W'(volt_r);
        count_nxt = count_r + COUNT_W'(1);
      end
      wslot_nxt = (slot_inc >= win_eff) ? '0 : RING_AW'(slot_inc);
    end

    if (cmd.div_load) begin
      quo_nxt = sum_r;
      rem_nxt = '0;
    end

    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, count_r}) begin
        rem_nxt = rem_sh - {1'b0, count_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
    end

    if (cmd.check) begin
      avg_nxt = avg_new;
      if (full_r > empty_r) begin
        for (int i = 0; i < 4; i++) begin
          if (!lev_r[i] && (a4 < lvl[i])) begin
            lev_nxt[i] = 1'b1;
            lev_ev[i]  = 1'b1;
          end else if (lev_r[i] && ({1'b0, a4} > ({1'b0, lvl[i]} + {1'b0, h4}))) begin
            lev_nxt[i] = 1'b0;
          end
        end
      end
      res_nxt.sample_taken = 1'b1;
      res_nxt.average_mv   = avg_new;
      res_nxt.level_events = lev_ev;
      res_nxt.critical_event    = 1'b0;
      res_nxt.overcurrent_event = 1'b0;
      res_nxt.reported_current  = '0;
      if (!crit_r && (avg_new <= crit_mv_r)) begin
        crit_nxt = 1'b1;
        res_nxt.critical_event = 1'b1;
      end else if (crit_r && ({1'b0, avg_new} > crit_rel)) begin
        crit_nxt = 1'b0;
      end
      if (oc_hit) begin
        secs_nxt = '0;
        res_nxt.overcurrent_event = 1'b1;
        res_nxt.reported_current  = cur_r;
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end

    // register writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        REG_FULL_MV: begin
          full_nxt = cfg_data;
          lev_nxt  = '0;
        end
        REG_EMPTY_MV: begin
          empty_nxt = cfg_data;
          lev_nxt   = '0;
        end
        REG_CRIT_MV:  crit_mv_nxt  = cfg_data;
        REG_HYST_MV:  hyst_nxt     = cfg_data;
        REG_OC_LIMIT: oc_lim_nxt   = cfg_data;
        REG_AVG_WINDOW: begin
          window_nxt = cfg_data[WIN_W-1:0];
          sum_nxt    = '0;
          count_nxt  = '0;
          wslot_nxt  = '0;
          avg_nxt    = '0;
        end
        REG_DEBOUNCE: debounce_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r      <= RST_FULL_MV;
      empty_r     <= RST_EMPTY_MV;
      crit_mv_r   <= RST_CRIT_MV;
      hyst_r      <= RST_HYST_MV;
      oc_lim_r    <= RST_OC_LIMIT;
      window_r    <= RST_WINDOW;
      debounce_r  <= RST_DEBOUNCE;
      sum_r       <= '0;
      count_r     <= '0;
      wslot_r     <= '0;
      lev_r       <= '0;
      crit_r      <= 1'b0;
      secs_r      <= SECONDS_MAX;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      full_r      <= full_nxt;
      empty_r     <= empty_nxt;
      crit_mv_r   <= crit_mv_nxt;
      hyst_r      <= hyst_nxt;
      oc_lim_r    <= oc_lim_nxt;
      window_r    <= window_nxt;
      debounce_r  <= debounce_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      wslot_r     <= wslot_nxt;
      lev_r       <= lev_nxt;
      crit_r      <= crit_nxt;
      secs_r      <= secs_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    volt_r <= volt_nxt;
    cur_r  <= cur_nxt;
    ap_r   <= ap_nxt;
    slot_r <= slot_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    if (cmd.load_out) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/battery_level_monitor_unit.sv
// top level of the battery level monitor
// Takes one item at a time. A tick, a clear or a sample under 500 mV goes from
// accept straight to the output load; a valid sample passes through accept,
// ring read and update, divider load, the shift-subtract divider that forms
// the moving average one quotient bit per cycle (23 steps for a 64-entry
// window), level check and output load. A result that is stalled at the
// output holds the block in its last step until it is taken. A finished result
// sits in the output register while the next item is taken in. Register writes
// are taken at any time but are meant to happen only while the block is idle;
// changing the window empties the average.
module battery_level_monitor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  blm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output blm_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blm_pkg::MV_W-1:0]      cfg_data
);
  import blm_pkg::*;

  blm_cmd_t    cmd;
  blm_status_t status;

  blm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  blm_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

### rtl/core/blm_checker.sv
// port-level checks of the battery level monitor and their binding
`include "battery_level_monitor_unit_assert.svh"

module blm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input blm_pkg::out_t out_data
);

  // a stalled result holds
  `BLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: after a transaction the input is stalled
  `BLM_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

  // events only come with a taken sample
  `BLM_ASSERT_NOW(a_events_need_sample, out_valid && !out_data.sample_taken,
    out_data.level_events == 4'd0 && !out_data.critical_event && !out_data.overcurrent_event)

  // reported current only accompanies an overcurrent event
  `BLM_ASSERT_NOW(a_report_only_on_oc, out_valid && !out_data.overcurrent_event,
    out_data.reported_current == '0)

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);
